// ===== sv/cbt_pkg.sv =====
package cbt_pkg;

    localparam int unsigned DataW     = 32;
    localparam int unsigned NumCand   = 12;
    localparam int unsigned RecipShift = 24;
    localparam int unsigned BrpMax    = 1024;
    localparam int unsigned ClocksMax = 25600;
    localparam logic [31:0] ClockReset = 32'd120000000;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_RATE = 2'd1,
        ST_NOT_MULT  = 2'd2,
        ST_NO_QUANTA = 2'd3
    } t_status;

    localparam logic [1:0] AddrClock = 2'd0;

    // candidates in pick order: closest sample point first, higher count on ties
    localparam logic [4:0] CandTq [NumCand] = '{
        5'd16, 5'd8, 5'd17, 5'd15, 5'd18, 5'd9, 5'd14, 5'd19, 5'd10, 5'd13, 5'd11, 5'd12};
    localparam logic [4:0] CandS1 [NumCand] = '{
        5'd13, 5'd6, 5'd14, 5'd12, 5'd15, 5'd7, 5'd11, 5'd16, 5'd8, 5'd10, 5'd9, 5'd10};
    localparam logic [3:0] CandS2 [NumCand] = '{
        4'd2, 4'd1, 4'd2, 4'd2, 4'd2, 4'd1, 4'd2, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1};

endpackage

// ===== sv/can_bit_timing_calculator.sv =====
// CAN bit timing calculator. Pulse start with a bit rate; busy is always low, so a new
// rate may be given every cycle. The result appears on the o_ ports for one cycle with
// o_done high, in request order, after passing through the request register, the
// one-bit-per-stage clock/rate divider, the per-quanta reciprocal multiplies, the
// divisibility checks and the pick. The receiver cannot stall the block; results must
// be taken the cycle they appear. clock_hz is sampled at start.
module can_bit_timing_calculator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_bit_rate,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [10:0] o_prescaler,
    output logic [4:0]  o_phase_seg1,
    output logic [3:0]  o_phase_seg2,
    output logic [2:0]  o_jump_width,
    output logic [14:0] o_bit_timing_word,
    output logic [3:0]  o_prescaler_ext,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cbt_pkg::*;

    logic [31:0] r_clock_hz;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign prdata = (paddr == AddrClock) ? r_clock_hz : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz <= ClockReset;
        end else if (psel && penable && pwrite && paddr == AddrClock) begin
            r_clock_hz <= pwdata;
        end
    end

    // divider pipeline
    logic              r_dv [0:DataW];
    logic              r_dz [0:DataW];
    logic [DataW-1:0]  r_dq [0:DataW];
    logic [DataW-1:0]  r_dr [0:DataW];
    logic [DataW-1:0]  r_dd [0:DataW];
    logic [DataW:0]    n_rr [0:DataW-1];
    logic              n_ge [0:DataW-1];

    always_comb begin
        for (int k = 0; k < DataW; k++) begin
            n_rr[k] = {r_dr[k], r_dq[k][DataW-1]};
            n_ge[k] = n_rr[k] >= {1'b0, r_dd[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DataW; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else begin
            r_dv[0] <= start;
            for (int k = 0; k < DataW; k++) begin
                r_dv[k+1] <= r_dv[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dq[0] <= r_clock_hz;
        r_dr[0] <= '0;
        r_dd[0] <= i_bit_rate;
        r_dz[0] <= (i_bit_rate == 32'd0);
        for (int k = 0; k < DataW; k++) begin
            r_dd[k+1] <= r_dd[k];
            r_dz[k+1] <= r_dz[k];
            r_dq[k+1] <= {r_dq[k][DataW-2:0], n_ge[k]};
            r_dr[k+1] <= n_ge[k] ? DataW'(n_rr[k] - {1'b0, r_dd[k]}) : n_rr[k][DataW-1:0];
        end
    end

    // multiply stage
    logic        r_mv;
    logic [1:0]  r_mst;
    logic [14:0] r_mx;
    logic [36:0] r_mp [NumCand];

    for (genvar g = 0; g < NumCand; g++) begin : g_mul
        localparam int unsigned Tq    = int'(CandTq[g]);
        localparam int unsigned Recip = ((1 << RecipShift) + Tq - 1) / Tq;
        always_ff @(posedge i_clk) begin
            r_mp[g] <= 37'({22'd0, r_dq[DataW][14:0]} * 37'(Recip));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else begin
            r_mv <= r_dv[DataW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_mx <= r_dq[DataW][14:0];
        if (r_dz[DataW]) begin
            r_mst <= ST_ZERO_RATE;
        end else if (r_dr[DataW] != '0) begin
            r_mst <= ST_NOT_MULT;
        end else if (r_dq[DataW] > 32'(ClocksMax)) begin
            r_mst <= ST_NO_QUANTA;
        end else begin
            r_mst <= ST_OK;
        end
    end

    // check stage
    logic        r_cv;
    logic [1:0]  r_cst;
    logic        r_ck [NumCand];
    logic [10:0] r_cb [NumCand];
    logic [12:0] n_q  [NumCand];
    logic [17:0] n_back [NumCand];

    always_comb begin
        for (int c = 0; c < NumCand; c++) begin
            n_q[c]    = r_mp[c][RecipShift+12:RecipShift];
            n_back[c] = 18'(n_q[c]) * 18'(CandTq[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= 1'b0;
        end else begin
            r_cv <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cst <= r_mst;
        for (int c = 0; c < NumCand; c++) begin
            r_ck[c] <= (n_back[c] == 18'(r_mx)) && (n_q[c] != '0)
                       && (n_q[c] <= 13'(BrpMax));
            r_cb[c] <= n_q[c][10:0];
        end
    end

    // pick stage
    logic [1:0]  n_st;
    logic [10:0] n_brp;
    logic [4:0]  n_s1;
    logic [3:0]  n_s2;
    logic        n_found;
    logic [10:0] n_bm1;
    logic [2:0]  n_sjw;

    always_comb begin
        n_found = 1'b0;
        n_brp   = '0;
        n_s1    = '0;
        n_s2    = '0;
        for (int c = NumCand - 1; c >= 0; c--) begin
            if (r_ck[c]) begin
                n_found = 1'b1;
                n_brp   = r_cb[c];
                n_s1    = CandS1[c];
                n_s2    = CandS2[c];
            end
        end
        n_st = r_cst;
        if (r_cst == ST_OK && !n_found) begin
            n_st = ST_NO_QUANTA;
        end
        n_bm1 = n_brp - 11'd1;
        n_sjw = (n_s2 < 4'd4) ? n_s2[2:0] : 3'd4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_cv;
        end
    end

    always_ff @(posedge i_clk) begin
        o_status <= n_st;
        if (n_st == ST_OK) begin
            o_prescaler       <= n_brp;
            o_phase_seg1      <= n_s1;
            o_phase_seg2      <= n_s2;
            o_jump_width      <= n_sjw;
            o_bit_timing_word <= {3'(n_s2 - 4'd1), 4'(n_s1 - 5'd1), 2'(n_sjw - 3'd1),
                                  n_bm1[5:0]};
            o_prescaler_ext   <= n_bm1[9:6];
        end else begin
            o_prescaler       <= '0;
            o_phase_seg1      <= '0;
            o_phase_seg2      <= '0;
            o_jump_width      <= '0;
            o_bit_timing_word <= '0;
            o_prescaler_ext   <= '0;
        end
    end

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cv |=> o_done)
        else $error("result lost");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (o_prescaler == '0 && o_bit_timing_word == '0))
        else $error("error result not zeroed");
    a_ok_brp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_OK) |-> (o_prescaler != '0 && o_phase_seg2 != '0))
        else $error("ok result with empty fields");
    a_zero_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mv && r_mst == ST_ZERO_RATE) |=> ##1 (o_status == ST_ZERO_RATE))
        else $error("zero rate status lost");

endmodule
